>>> src/pewb_pkg.sv
// shared types, constants and fixed-point helpers for the particle step pipeline
`default_nettype none

package pewb_pkg;

  localparam int NSTG = 13;

  localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  // register reset values, Q16.16
  localparam logic [16:0] RST_STEP = 17'd655;
  localparam logic [16:0] RST_REST = 17'd52429;
  localparam logic [16:0] RST_FRIC = 17'd32768;
  localparam logic [30:0] RST_WIDTH = 31'd52428800;
  localparam logic [30:0] RST_HEIGHT = 31'd39321600;
  localparam logic [30:0] RST_DIAM = 31'd1310720;

  typedef enum logic [2:0] {
    REG_STEP   = 3'd0,
    REG_REST   = 3'd1,
    REG_FRIC   = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4,
    REG_DIAM   = 3'd5
  } cfg_idx_t;

  // wall hit bit positions
  localparam int HIT_LEFT = 0;
  localparam int HIT_RIGHT = 1;
  localparam int HIT_TOP = 2;
  localparam int HIT_FLOOR = 3;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [49:0] pa;
    logic signed [49:0] pb;
    logic signed [31:0] ra;
    logic signed [31:0] rb;
    logic [3:0]         hits;
  } stage_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'(MAX32)) r = MAX32;
    else if (v < 35'(MIN32)) r = MIN32;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [34:0] s;
    s = 35'(a) + 35'(b);
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
    logic signed [31:0] r;
    if (a == MIN32) r = MAX32;
    else r = -a;
    return r;
  endfunction

  // unsigned 17-bit factor times signed 32-bit value, exact
  function automatic logic signed [49:0] mul_q(input logic [16:0] k,
                                               input logic signed [31:0] v);
    logic signed [17:0] ks;
    ks = $signed({1'b0, k});
    return 50'(ks) * 50'(v);
  endfunction

  // Q18.32 to Q16.16: add half, floor shift, saturate; neg negates the exact product
  function automatic logic signed [31:0] rnd_q(input logic signed [49:0] p,
                                               input logic neg);
    logic signed [50:0] t;
    logic signed [50:0] sh;
    if (neg) t = 51'sd32768 - 51'(p);
    else t = 51'(p) + 51'sd32768;
    sh = t >>> 16;
    return sat32(sh[34:0]);
  endfunction

endpackage

`default_nettype wire

>>> src/particle_euler_wall_bounce.sv
// top level: one semi-implicit euler step per particle with wall bounce, 13-stage pipeline
//
// One particle state is taken per clock while the output side keeps taking transfers;
// the pipeline is a chain of five multiply-then-round steps (two for the euler
// update, up to three friction scalings on x velocity), each a multiplier stage
// followed by a rounding stage, plus the add and wall-compare stages. Every stage
// moves on its own when the stage after it is empty or moving, so bubbles close up
// and a stalled output still lets new items in until the pipeline is full. The user
// must see that registers are written through the APB port only while no item is in
// flight; the block itself does not enforce this. Values are Q16.16 and all results saturate.
`default_nettype none

module particle_euler_wall_bounce import pewb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y (32 bits each, from bit 0 up)
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [191:0] in_tdata,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_acc_x, new_acc_y (32 each),
  // wall_hits (4), zero pad (4), from bit 0 up
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [199:0]      out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [16:0] step_r, rest_r, fric_r;
  logic [30:0] width_r, height_r, diam_r;

  cfg_idx_t cfg_idx;
  assign cfg_idx = cfg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= RST_STEP;
      rest_r   <= RST_REST;
      fric_r   <= RST_FRIC;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      diam_r   <= RST_DIAM;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_idx)
        REG_STEP:   step_r   <= cfg_pwdata[16:0];
        REG_REST:   rest_r   <= cfg_pwdata[16:0];
        REG_FRIC:   fric_r   <= cfg_pwdata[16:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[30:0];
        REG_HEIGHT: height_r <= cfg_pwdata[30:0];
        REG_DIAM:   diam_r   <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_STEP:   cfg_prdata = {15'd0, step_r};
      REG_REST:   cfg_prdata = {15'd0, rest_r};
      REG_FRIC:   cfg_prdata = {15'd0, fric_r};
      REG_WIDTH:  cfg_prdata = {1'b0, width_r};
      REG_HEIGHT: cfg_prdata = {1'b0, height_r};
      REG_DIAM:   cfg_prdata = {1'b0, diam_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // pipeline
  stage_t st_in;
  stage_t st_r   [1:NSTG];
  stage_t st_nxt [1:NSTG];
  logic   v_r    [1:NSTG];
  logic   ld     [1:NSTG];

  always_comb begin
    st_in      = '0;
    st_in.px   = $signed(in_tdata[31:0]);
    st_in.py   = $signed(in_tdata[63:32]);
    st_in.vx   = $signed(in_tdata[95:64]);
    st_in.vy   = $signed(in_tdata[127:96]);
    st_in.ax   = $signed(in_tdata[159:128]);
    st_in.ay   = $signed(in_tdata[191:160]);
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ld[NSTG] = !v_r[NSTG] || out_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_tready = ld[1];

  always_comb begin
    logic signed [31:0] pxl, pyt, ax1;
    logic signed [32:0] sx, sy;
    logic               left, right, top, flr;

    // dt * acceleration
    st_nxt[1]    = st_in;
    st_nxt[1].pa = mul_q(step_r, st_in.ax);
    st_nxt[1].pb = mul_q(step_r, st_in.ay);

    st_nxt[2]    = st_r[1];
    st_nxt[2].ra = rnd_q(st_r[1].pa, 1'b0);
    st_nxt[2].rb = rnd_q(st_r[1].pb, 1'b0);

    st_nxt[3]    = st_r[2];
    st_nxt[3].vx = add_sat(st_r[2].vx, st_r[2].ra);
    st_nxt[3].vy = add_sat(st_r[2].vy, st_r[2].rb);

    // dt * new velocity
    st_nxt[4]    = st_r[3];
    st_nxt[4].pa = mul_q(step_r, st_r[3].vx);
    st_nxt[4].pb = mul_q(step_r, st_r[3].vy);

    st_nxt[5]    = st_r[4];
    st_nxt[5].ra = rnd_q(st_r[4].pa, 1'b0);
    st_nxt[5].rb = rnd_q(st_r[4].pb, 1'b0);

    st_nxt[6]    = st_r[5];
    st_nxt[6].px = add_sat(st_r[5].px, st_r[5].ra);
    st_nxt[6].py = add_sat(st_r[5].py, st_r[5].rb);

    // wall checks, each on what the previous one left
    left  = st_r[6].px < 0;
    pxl   = left ? 32'sd0 : st_r[6].px;
    sx    = 33'(pxl) + $signed({2'b00, diam_r});
    right = sx >= $signed({2'b00, width_r});
    top   = st_r[6].py < 0;
    pyt   = top ? 32'sd0 : st_r[6].py;
    sy    = 33'(pyt) + $signed({2'b00, diam_r});
    flr   = sy >= $signed({2'b00, height_r});
    ax1   = left ? neg_sat(st_r[6].ax) : st_r[6].ax;

    st_nxt[7]    = st_r[6];
    st_nxt[7].px = right ? ($signed({1'b0, width_r}) - $signed({1'b0, diam_r})) : pxl;
    st_nxt[7].py = flr ? ($signed({1'b0, height_r}) - $signed({1'b0, diam_r})) : pyt;
    st_nxt[7].ax = right ? neg_sat(ax1) : ax1;
    st_nxt[7].vy = top ? neg_sat(st_r[6].vy) : st_r[6].vy;
    st_nxt[7].hits[HIT_LEFT]  = left;
    st_nxt[7].hits[HIT_RIGHT] = right;
    st_nxt[7].hits[HIT_TOP]   = top;
    st_nxt[7].hits[HIT_FLOOR] = flr;

    // left wall damping on x, floor bounce on y
    st_nxt[8]    = st_r[7];
    st_nxt[8].pa = mul_q(fric_r, st_r[7].vx);
    st_nxt[8].pb = mul_q(rest_r, st_r[7].vy);

    st_nxt[9]    = st_r[8];
    if (st_r[8].hits[HIT_LEFT]) st_nxt[9].vx = rnd_q(st_r[8].pa, 1'b1);
    if (st_r[8].hits[HIT_FLOOR]) st_nxt[9].vy = rnd_q(st_r[8].pb, 1'b1);

    // right wall damping
    st_nxt[10]    = st_r[9];
    st_nxt[10].pa = mul_q(fric_r, st_r[9].vx);

    st_nxt[11]    = st_r[10];
    if (st_r[10].hits[HIT_RIGHT]) st_nxt[11].vx = rnd_q(st_r[10].pa, 1'b1);

    // floor friction on x, no sign change
    st_nxt[12]    = st_r[11];
    st_nxt[12].pa = mul_q(fric_r, st_r[11].vx);

    st_nxt[13]    = st_r[12];
    if (st_r[12].hits[HIT_FLOOR]) st_nxt[13].vx = rnd_q(st_r[12].pa, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NSTG; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      if (ld[1]) v_r[1] <= in_tvalid;
      for (int k = 2; k <= NSTG; k++) begin
        if (ld[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NSTG; k++) begin
      if (ld[k]) st_r[k] <= st_nxt[k];
    end
  end

  assign out_tvalid = v_r[NSTG];
  assign out_tdata  = {4'b0000, st_r[NSTG].hits, st_r[NSTG].ay, st_r[NSTG].ax,
                       st_r[NSTG].vy, st_r[NSTG].vx, st_r[NSTG].py, st_r[NSTG].px};

endmodule

`default_nettype wire

>>> src/pewb_checker.sv
// port-level checker for the particle step block, bound to the top level
`default_nettype none

module pewb_checker import pewb_pkg::*; (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [199:0] out_tdata
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // nothing left in flight after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a left hit without a right hit pins x to zero
  a_left_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[192 + HIT_LEFT] && !out_tdata[192 + HIT_RIGHT]
      |-> out_tdata[31:0] == 32'd0)
    else $error("left wall hit without x clamp");

  // a top hit without a floor hit pins y to zero
  a_top_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[192 + HIT_TOP] && !out_tdata[192 + HIT_FLOOR]
      |-> out_tdata[63:32] == 32'd0)
    else $error("top wall hit without y clamp");

endmodule

bind particle_euler_wall_bounce pewb_checker u_pewb_checker (.*);

`default_nettype wire
